// ----- design/ramp_setpoint_pid_heater_unit_assert.svh -----
// Assertion macros for the ramp setpoint PID heater unit.
// Included by the top level; no other dependencies.
`ifndef RAMP_SETPOINT_PID_HEATER_UNIT_ASSERT_SVH
`define RAMP_SETPOINT_PID_HEATER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RSPH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsph assertion failed");
`define RSPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsph assertion failed");
`else
`define RSPH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RSPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/rsph_pkg.sv -----
// Shared types and constants of the ramp setpoint PID heater unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package rsph_pkg;

  // Command codes of an input transaction.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CANCEL = 2'd2
  } cmd_e;

  // Configuration register indexes.
  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_DEADBAND = 3'd3;
  localparam logic [2:0] REG_DUTY_MAX = 3'd4;

  localparam int unsigned ErrW     = 20;
  localparam int unsigned NumW     = 29;   // |4*(target-base)*elapsed|
  localparam int unsigned DivSteps = 29;   // one quotient bit per cycle
  localparam int unsigned CntW     = 5;
  // floor(x/20) == (x*52429)>>20 for every 16-bit x.
  localparam logic [16:0] Recip20  = 17'd52429;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIVLD, S_DIV, S_ERR, S_MUL, S_APPLY, S_DUTY, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_P, MUL_I, MUL_D
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     prep;
    logic     div_load;
    logic     div_step;
    logic     err_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     apply_cmd;
    logic     apply_duty;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ctl_tick;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- design/ramp_setpoint_pid_heater_unit.sv -----
// Top level of the ramp setpoint PID heater unit: configuration registers,
// controller and datapath. Depends on rsph_pkg, rsph_ctrl, rsph_datapath.
//
// Usage: each input transaction carries a command (start segment, one-second
// tick or cancel) with its fields, and gives exactly one result transaction
// with the duty, the running flag, the segment end flag and the last error.
// Start, cancel, idle ticks, the segment end tick and a skipped first tick
// go from acceptance straight to the output register state.
// A control tick runs a bit-serial divider for the ramp setpoint and three
// products through one shared multiplier, in the states prep, divider load,
// divide, error, multiply, apply and duty, before the output register state.
// One transaction is in work at a time.
// The result waits in an output register, so the next transaction is taken
// while the receiver stalls; its own result then waits until the register
// is free. Reset loads the gains (kp 1.0, ki 0, kd 0), deadband 4 and
// duty_max 100, stops the segment and clears duty, error and window.
// Configuration writes take effect at the clock edge of the write enable.
`default_nettype none
`include "ramp_setpoint_pid_heater_unit_assert.svh"
module ramp_setpoint_pid_heater_unit
  import rsph_pkg::*;
#(
  parameter int unsigned WINDOW = 8
)(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [12:0] measured_temp_i,
  input  wire logic [15:0] elapsed_s_i,
  input  wire logic [10:0] base_temp_i,
  input  wire logic [10:0] target_temp_i,
  input  wire logic [15:0] seg_duration_i,
  input  wire logic        hold_mode_i,
  input  wire logic        skip_first_i,
  input  wire logic        start_full_i,
  input  wire logic        clear_window_i,
  input  wire logic        cool_at_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      duty_o,
  output logic             active_o,
  output logic             seg_done_o,
  output logic signed [19:0] error_q2_o
);

  logic [15:0] kp_q, ki_q, kd_q, duty_max_q;
  logic [11:0] deadband_q;
  ctrl_cmd_t   ctrl_cmd;
  dp_status_t  dp_status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= 16'd256;
      ki_q       <= '0;
      kd_q       <= '0;
      deadband_q <= 12'd4;
      duty_max_q <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KP:       kp_q       <= cfg_data_i;
        REG_KI:       ki_q       <= cfg_data_i;
        REG_KD:       kd_q       <= cfg_data_i;
        REG_DEADBAND: deadband_q <= cfg_data_i[11:0];
        REG_DUTY_MAX: duty_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rsph_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  rsph_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .status_o        (dp_status),
    .kp_i            (kp_q),
    .ki_i            (ki_q),
    .kd_i            (kd_q),
    .deadband_i      (deadband_q),
    .duty_max_i      (duty_max_q),
    .cmd_in_i        (cmd_i),
    .measured_temp_i (measured_temp_i),
    .elapsed_s_i     (elapsed_s_i),
    .base_temp_i     (base_temp_i),
    .target_temp_i   (target_temp_i),
    .seg_duration_i  (seg_duration_i),
    .hold_mode_i     (hold_mode_i),
    .skip_first_i    (skip_first_i),
    .start_full_i    (start_full_i),
    .clear_window_i  (clear_window_i),
    .cool_at_end_i   (cool_at_end_i),
    .duty_o          (duty_o),
    .active_o        (active_o),
    .seg_done_o      (seg_done_o),
    .error_q2_o      (error_q2_o)
  );

  // One transaction in work at a time.
  `RSPH_ASSERT_NEXT(a_one_in_work, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A segment end result never reports a running segment.
  `RSPH_ASSERT_IMPL(a_done_stops, clk_i, rst_ni, out_valid_o && seg_done_o, !active_o)

endmodule
`default_nettype wire

// ----- design/rsph_ctrl.sv -----
// Controller state machine of the heater unit: sequences one transaction.
// Depends on rsph_pkg.
`default_nettype none
module rsph_ctrl
  import rsph_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);
  localparam logic [CntW-1:0] MulLast = CntW'(3);

  // State, counter and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_P;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.ctl_tick ? S_PREP : S_OUT;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = S_DIVLD;
      end
      S_DIVLD: begin
        cmd_o.div_load = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = S_ERR;
      end
      S_ERR: begin
        cmd_o.err_step = 1'b1;
        cnt_d = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        // Three products through one multiplier, each accumulated in the cycle after it is formed.
        cmd_o.mul_en = (cnt_q != MulLast);
        cmd_o.acc_en = (cnt_q != '0);
        unique case (cnt_q[1:0])
          2'd1:    cmd_o.mul_sel = MUL_I;
          2'd2:    cmd_o.mul_sel = MUL_D;
          default: cmd_o.mul_sel = MUL_P;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MulLast) state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply_cmd = 1'b1;
        state_d = S_DUTY;
      end
      S_DUTY: begin
        cmd_o.apply_duty = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- design/rsph_datapath.sv -----
// Datapath of the heater unit: segment state, error window memory,
// serial divider, shared multiplier and result registers. Depends on rsph_pkg.
`default_nettype none
module rsph_datapath
  import rsph_pkg::*;
#(
  parameter int unsigned WINDOW = 8
)(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_cmd_t   cmd_i,
  output dp_status_t       status_o,
  input  wire logic [15:0] kp_i,
  input  wire logic [15:0] ki_i,
  input  wire logic [15:0] kd_i,
  input  wire logic [11:0] deadband_i,
  input  wire logic [15:0] duty_max_i,
  input  wire logic [1:0]  cmd_in_i,
  input  wire logic [12:0] measured_temp_i,
  input  wire logic [15:0] elapsed_s_i,
  input  wire logic [10:0] base_temp_i,
  input  wire logic [10:0] target_temp_i,
  input  wire logic [15:0] seg_duration_i,
  input  wire logic        hold_mode_i,
  input  wire logic        skip_first_i,
  input  wire logic        start_full_i,
  input  wire logic        clear_window_i,
  input  wire logic        cool_at_end_i,
  output logic [15:0]      duty_o,
  output logic             active_o,
  output logic             seg_done_o,
  output logic signed [ErrW-1:0] error_q2_o
);

  localparam int unsigned PtrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW = ErrW + PtrW;
  localparam int unsigned PrdW = 17 + SumW;
  localparam int unsigned AccW = PrdW + 2;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW - 1);

  // Segment and control state.
  logic                   running_q;
  logic [2:0]             flags_q;     // bit0 hold, bit1 skip_first, bit2 cool
  logic [10:0]            base_q, target_q;
  logic [15:0]            length_q;
  logic signed [ErrW-1:0] last_err_q;
  logic signed [SumW-1:0] sum_q;
  logic [PtrW-1:0]        ptr_q;
  logic [WINDOW-1:0]      vld_q;
  logic signed [31:0]     dcmd_q;
  logic [15:0]            duty_q;
  logic                   done_q;
  logic [12:0]            meas_q;
  logic [15:0]            elap_q;

  // Work registers.
  logic [11:0]            d20_q;
  logic [26:0]            nmag_q;
  logic [NumW-1:0]        div_n_q;
  logic [15:0]            div_r_q;
  logic signed [ErrW-1:0] win_rd_q;
  logic                   old_vld_q;
  logic signed [20:0]     diff_q;
  logic signed [PrdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;

  logic signed [ErrW-1:0] win_mem [WINDOW];

  // Transaction decode at acceptance.
  logic is_start, is_tick, is_cancel, seg_end;
  assign is_start  = (cmd_in_i == CMD_START);
  assign is_tick   = (cmd_in_i == CMD_TICK);
  assign is_cancel = (cmd_in_i == CMD_CANCEL);
  assign seg_end   = is_tick && running_q && (elapsed_s_i >= length_q);
  assign status_o.ctl_tick = is_tick && running_q && (elapsed_s_i < length_q) &&
                             !(flags_q[1] && (elapsed_s_i == 16'd0));

  // Ramp difference magnitude and sign.
  logic signed [11:0] tb_diff;
  logic [10:0]        tb_mag;
  assign tb_diff = $signed({1'b0, target_q}) - $signed({1'b0, base_q});
  assign tb_mag  = tb_diff[11] ? 11'(-tb_diff) : tb_diff[10:0];

  // Duty divided by twenty through the reciprocal.
  logic [32:0] d20_prod;
  assign d20_prod = {17'd0, duty_q} * {16'd0, Recip20};

  // One restoring division step.
  logic [16:0] div_t;
  logic        div_ge;
  assign div_t  = {div_r_q, div_n_q[NumW-1]};
  assign div_ge = (div_t >= {1'b0, length_q});

  // Setpoint, compensated temperature and error.
  logic signed [16:0] setp;
  logic signed [16:0] q_s;
  logic [14:0]        comp;
  logic signed [17:0] err18;
  logic signed [ErrW-1:0] err;
  assign q_s   = $signed({3'b000, div_n_q[13:0]});
  assign setp  = flags_q[0] ? $signed({4'b0000, target_q, 2'b00})
               : (tb_diff[11] ? $signed({4'b0000, base_q, 2'b00}) - q_s
                              : $signed({4'b0000, base_q, 2'b00}) + q_s);
  assign comp  = {2'b00, meas_q} + {1'b0, d20_q, 2'b00};
  // The error range is far inside 20 bits, so the error is taken without saturation.
  assign err18 = 18'(setp) - $signed({3'b000, comp});
  assign err   = ErrW'(err18);

  logic signed [ErrW-1:0] old_val;
  assign old_val = old_vld_q ? win_rd_q : '0;

  // Multiplier operands.
  logic signed [16:0]     op_a;
  logic signed [SumW-1:0] op_b;
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_I: begin
        op_a = $signed({1'b0, ki_i});
        op_b = sum_q;
      end
      MUL_D: begin
        op_a = $signed({1'b0, kd_i});
        op_b = SumW'(diff_q);
      end
      default: begin
        op_a = $signed({1'b0, kp_i});
        op_b = SumW'(last_err_q);
      end
    endcase
  end

  // Rounding to nearest, ties away from zero, and saturation to 32 bits.
  logic [AccW-1:0]    mag;
  logic [63:0]        q64;
  logic signed [31:0] pid;
  assign mag = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign q64 = 64'((mag + AccW'(512)) >> 10);
  always_comb begin
    if (acc_q[AccW-1]) begin
      pid = (q64 > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed(q64));
    end else begin
      pid = (q64 > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q64[31:0]);
    end
  end

  logic outside_db;
  assign outside_db = (21'(last_err_q) > $signed({9'd0, deadband_i})) ||
                      (21'(last_err_q) < -$signed({9'd0, deadband_i}));

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      flags_q    <= '0;
      base_q     <= '0;
      target_q   <= '0;
      length_q   <= 16'd1;
      last_err_q <= '0;
      sum_q      <= '0;
      ptr_q      <= '0;
      vld_q      <= '0;
      dcmd_q     <= '0;
      duty_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        done_q <= seg_end;
        if (is_start) begin
          running_q <= 1'b1;
          base_q    <= base_temp_i;
          target_q  <= target_temp_i;
          length_q  <= (seg_duration_i == 16'd0) ? 16'd1 : seg_duration_i;
          flags_q   <= {cool_at_end_i, skip_first_i, hold_mode_i};
          if (start_full_i) duty_q <= duty_max_i;
          if (clear_window_i) begin
            vld_q <= '0;
            sum_q <= '0;
            ptr_q <= '0;
          end
        end else if (seg_end) begin
          running_q <= 1'b0;
          if (flags_q[2]) duty_q <= '0;
        end else if (is_cancel) begin
          running_q <= 1'b0;
          duty_q    <= '0;
        end
      end
      // Window push of the previous error and new error.
      if (cmd_i.err_step) begin
        sum_q        <= sum_q - SumW'(old_val) + SumW'(last_err_q);
        vld_q[ptr_q] <= 1'b1;
        ptr_q        <= (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
        last_err_q   <= err;
      end
      if (cmd_i.apply_cmd && outside_db) dcmd_q <= pid;
      // Duty from the command word, clamped to zero and duty_max; a zero command keeps the duty within duty_max.
      if (cmd_i.apply_duty) begin
        if (dcmd_q > 32'sd0) begin
          duty_q <= (dcmd_q > $signed({16'd0, duty_max_i})) ? duty_max_i : dcmd_q[15:0];
        end else if (dcmd_q < 32'sd0) begin
          duty_q <= '0;
        end else if (duty_q > duty_max_i) begin
          duty_q <= duty_max_i;
        end
      end
    end
  end

  // Window memory, written and read at the pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.err_step) win_mem[ptr_q] <= last_err_q;
    if (cmd_i.prep) win_rd_q <= win_mem[ptr_q];
  end

  // Work registers of the tick computation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      meas_q <= measured_temp_i;
      elap_q <= elapsed_s_i;
    end
    if (cmd_i.prep) begin
      old_vld_q <= vld_q[ptr_q];
      d20_q     <= d20_prod[31:20];
      nmag_q    <= {16'd0, tb_mag} * {11'd0, elap_q};
    end
    if (cmd_i.div_load) begin
      div_n_q <= {nmag_q, 2'b00};
      div_r_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_r_q <= div_ge ? 16'(div_t - {1'b0, length_q}) : div_t[15:0];
      div_n_q <= {div_n_q[NumW-2:0], div_ge};
    end
    if (cmd_i.err_step) begin
      diff_q <= 21'(err) - 21'(last_err_q);
      acc_q  <= '0;
    end
    if (cmd_i.mul_en) prod_q <= PrdW'(op_a) * PrdW'(op_b);
    if (cmd_i.acc_en) acc_q <= acc_q + AccW'(prod_q);
    if (cmd_i.out_load) begin
      duty_o     <= duty_q;
      active_o   <= running_q;
      seg_done_o <= done_q;
      error_q2_o <= last_err_q;
    end
  end

endmodule
`default_nettype wire

// ----- verif/ramp_setpoint_pid_heater_unit_tb.sv -----
// Self-checking testbench of the ramp setpoint PID heater unit.
// Depends on rsph_pkg and ramp_setpoint_pid_heater_unit; reads no files.
`default_nettype none
module ramp_setpoint_pid_heater_unit_tb;
  import rsph_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [12:0] measured;
    logic [15:0] elapsed;
    logic [10:0] base;
    logic [10:0] target;
    logic [15:0] duration;
    logic        hold, skip, full, clr, cool;
  } heater_item_t;

  typedef struct {
    logic [15:0]        duty;
    logic               active;
    logic               done;
    logic signed [19:0] err;
  } heater_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic [12:0] measured_temp_i = '0;
  logic [15:0] elapsed_s_i = '0;
  logic [10:0] base_temp_i = '0;
  logic [10:0] target_temp_i = '0;
  logic [15:0] seg_duration_i = '0;
  logic hold_mode_i = 1'b0, skip_first_i = 1'b0, start_full_i = 1'b0;
  logic clear_window_i = 1'b0, cool_at_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] duty_o;
  logic active_o, seg_done_o;
  logic signed [19:0] error_q2_o;

  ramp_setpoint_pid_heater_unit i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Predicted controller state and register copies.
  longint gain_p, gain_i, gain_d, band, duty_cap;
  longint seg_running, seg_hold, seg_skip, seg_cool;
  longint ramp_from, ramp_to, ramp_len;
  longint prev_err, err_sum, hist_ptr, duty_cmd, duty_level;
  longint err_hist[8];

  heater_item_t   pending_items[$];
  heater_result_t expected_results[$];
  int mismatches = 0;
  bit in_taken = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // One step of the heater controller for one accepted transaction.
  function automatic heater_result_t heater_step(input heater_item_t it);
    heater_result_t r;
    longint comp, setp, acc, mag, q, err, diff;
    logic done;
    done = 1'b0;
    case (it.cmd)
      CMD_START: begin
        seg_running = 1;
        ramp_from = it.base;
        ramp_to = it.target;
        ramp_len = (it.duration == 0) ? 1 : it.duration;
        seg_hold = it.hold;
        seg_skip = it.skip;
        seg_cool = it.cool;
        if (it.full) duty_level = duty_cap;
        if (it.clr) begin
          foreach (err_hist[k]) err_hist[k] = 0;
          err_sum = 0;
          hist_ptr = 0;
        end
      end
      CMD_TICK: begin
        if (seg_running != 0) begin
          if (longint'(it.elapsed) >= ramp_len) begin
            seg_running = 0;
            done = 1'b1;
            if (seg_cool != 0) duty_level = 0;
          end else if (!(seg_skip != 0 && it.elapsed == 0)) begin
            comp = longint'(it.measured) + 4 * (duty_level / 20);
            if (seg_hold != 0) setp = 4 * ramp_to;
            else setp = 4 * ramp_from
                      + (4 * (ramp_to - ramp_from) * longint'(it.elapsed)) / ramp_len;
            err = setp - comp;
            if (err > 524287) err = 524287;
            if (err < -524288) err = -524288;
            // The window holds previous errors, so the old one goes in first.
            err_sum = err_sum - err_hist[hist_ptr] + prev_err;
            err_hist[hist_ptr] = prev_err;
            hist_ptr = (hist_ptr + 1) % 8;
            diff = err - prev_err;
            prev_err = err;
            if (err > band || err < -band) begin
              acc = gain_p * err + gain_i * err_sum + gain_d * diff;
              mag = (acc < 0) ? -acc : acc;
              q = (mag + 512) >>> 10;
              if (acc < 0) duty_cmd = (q > 64'd2147483648) ? -64'sd2147483648 : -q;
              else duty_cmd = (q > 2147483647) ? 2147483647 : q;
            end
            if (duty_cmd > 0) duty_level = duty_cmd;
            else if (duty_cmd < 0) duty_level = 0;
            if (duty_level > duty_cap) duty_level = duty_cap;
          end
        end
      end
      CMD_CANCEL: begin
        seg_running = 0;
        duty_level = 0;
      end
      default: ;
    endcase
    r.duty = duty_level[15:0];
    r.active = seg_running[0];
    r.done = done;
    r.err = prev_err[19:0];
    return r;
  endfunction

  // Driver: presents queued transactions at the falling edge with random gaps.
  always @(negedge clk_i) begin
    automatic logic nv = in_valid_i;
    automatic heater_item_t it;
    if (in_taken) begin
      nv = 1'b0;
      in_taken = 1'b0;
    end
    if (!nv && rst_ni) begin
      if (send_gap > 0) send_gap--;
      else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        cmd_i <= it.cmd;
        measured_temp_i <= it.measured;
        elapsed_s_i <= it.elapsed;
        base_temp_i <= it.base;
        target_temp_i <= it.target;
        seg_duration_i <= it.duration;
        hold_mode_i <= it.hold;
        skip_first_i <= it.skip;
        start_full_i <= it.full;
        clear_window_i <= it.clr;
        cool_at_end_i <= it.cool;
        nv = 1'b1;
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
    end
    in_valid_i <= nv;
    // Receiver stalls for a drawn number of cycles before each result.
    if (recv_stall > 0) begin
      out_ready_i <= 1'b0;
      recv_stall--;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  // Monitor: predicts on input transactions and checks output transactions.
  always @(posedge clk_i) begin
    automatic heater_item_t it;
    automatic heater_result_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      it.cmd = cmd_i; it.measured = measured_temp_i; it.elapsed = elapsed_s_i;
      it.base = base_temp_i; it.target = target_temp_i; it.duration = seg_duration_i;
      it.hold = hold_mode_i; it.skip = skip_first_i; it.full = start_full_i;
      it.clr = clear_window_i; it.cool = cool_at_end_i;
      expected_results.push_back(heater_step(it));
      in_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report("unexpected result transaction", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (duty_o !== want.duty) report("duty", duty_o, want.duty);
        if (active_o !== want.active) report("active", active_o, want.active);
        if (seg_done_o !== want.done) report("seg_done", seg_done_o, want.done);
        if (error_q2_o !== want.err) report("error_q2", error_q2_o, want.err);
      end
      recv_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    end
  end

  task automatic push_item(input logic [1:0] cmd, input int measured, input int elapsed,
                           input int base, input int target, input int duration,
                           input logic [4:0] flags);
    heater_item_t it;
    it.cmd = cmd; it.measured = 13'(measured); it.elapsed = 16'(elapsed);
    it.base = 11'(base); it.target = 11'(target); it.duration = 16'(duration);
    {it.cool, it.clr, it.full, it.skip, it.hold} = flags;
    pending_items.push_back(it);
  endtask

  task automatic push_noise();
    push_item($urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
              $urandom_range(0, 8191), $urandom_range(0, 65535),
              $urandom_range(0, 2047), $urandom_range(0, 2047),
              $urandom_range(0, 65535), 5'($urandom));
  endtask

  // A start followed by ticks with non-decreasing elapsed time, near the setpoint, at times ended by a cancel.
  task automatic push_segment(output int count);
    int base, target, dur, e, sp, meas;
    logic [4:0] flags;
    base = $urandom_range(0, 1270);
    target = $urandom_range(0, 1270);
    dur = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : $urandom_range(0, 30);
    flags = 5'($urandom);
    push_item(CMD_START, 0, 0, base, target, dur, flags);
    count = 1;
    e = $urandom_range(0, 1) ? 0 : $urandom_range(0, 2);
    while (count < 60) begin
      sp = flags[0] ? 4 * target : 4 * base + (4 * (target - base) * longint'(e)) / (dur == 0 ? 1 : dur);
      meas = sp + $urandom_range(0, 80) - 40;
      if ($urandom_range(0, 7) == 0) meas = $urandom_range(0, 8191);
      if (meas < 0) meas = 0;
      if (meas > 8191) meas = 8191;
      push_item(CMD_TICK, meas, e, 0, 0, 0, 5'($urandom));
      count++;
      if (e >= dur && $urandom_range(0, 3) != 0) break;
      if ($urandom_range(0, 40) == 0) begin
        push_item(CMD_CANCEL, 0, 0, 0, 0, 0, 5'd0);
        count++;
        break;
      end
      e += (dur > 60) ? $urandom_range(1, dur / 20 + 1) : $urandom_range(0, 2);
      if (e > 65535) e = 65535;
    end
  endtask

  // Wait until the block is idle so that a register can be written.
  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_KP: gain_p = val;
      REG_KI: gain_i = val;
      REG_KD: gain_d = val;
      REG_DEADBAND: band = val[11:0];
      REG_DUTY_MAX: duty_cap = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int n, cnt, phase;
    gain_p = 256; gain_i = 0; gain_d = 0; band = 4; duty_cap = 100;
    seg_running = 0; seg_hold = 0; seg_skip = 0; seg_cool = 0;
    ramp_from = 0; ramp_to = 0; ramp_len = 1;
    prev_err = 0; err_sum = 0; hist_ptr = 0; duty_cmd = 0; duty_level = 0;
    foreach (err_hist[k]) err_hist[k] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: idle tick and cancel, zero duration, extremes, restarts.
    push_item(CMD_TICK, 5080, 5, 0, 0, 0, 5'd0);
    push_item(CMD_CANCEL, 0, 0, 0, 0, 0, 5'd0);
    push_item(2'd3, 8191, 65535, 2047, 2047, 65535, 5'h1f);
    push_item(CMD_START, 0, 0, 0, 1270, 0, 5'b00100);
    push_item(CMD_TICK, 0, 0, 0, 0, 0, 5'd0);
    push_item(CMD_TICK, 0, 1, 0, 0, 0, 5'd0);
    push_item(CMD_START, 0, 0, 1270, 0, 100, 5'b10110);
    push_item(CMD_TICK, 5080, 0, 0, 0, 0, 5'd0);
    push_item(CMD_TICK, 5080, 50, 0, 0, 0, 5'd0);
    push_item(CMD_TICK, 8191, 99, 0, 0, 0, 5'd0);
    push_item(CMD_TICK, 0, 65535, 0, 0, 0, 5'd0);
    push_item(CMD_START, 0, 0, 200, 1270, 65535, 5'b01001);
    push_item(CMD_TICK, 0, 3, 0, 0, 0, 5'd0);
    push_item(CMD_TICK, 4000, 65534, 0, 0, 0, 5'd0);
    push_item(CMD_START, 0, 0, 2047, 2047, 10, 5'b01000);
    push_item(CMD_TICK, 100, 4, 0, 0, 0, 5'd0);
    push_item(CMD_CANCEL, 0, 0, 0, 0, 0, 5'd0);
    push_item(CMD_TICK, 100, 4, 0, 0, 0, 5'd0);
    drain();

    // Random phases, each under its own register setting.
    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin write_reg(REG_KP, 16'hffff); write_reg(REG_KI, 16'hffff);
                 write_reg(REG_KD, 16'hffff); write_reg(REG_DEADBAND, 16'd0);
                 write_reg(REG_DUTY_MAX, 16'hffff); end
        1: begin write_reg(REG_KP, 16'd0); write_reg(REG_KI, 16'd0);
                 write_reg(REG_KD, 16'd0); write_reg(REG_DEADBAND, 16'd4095);
                 write_reg(REG_DUTY_MAX, 16'd1); end
        2: write_reg(REG_DUTY_MAX, 16'd0);
        default: begin
          write_reg(REG_KP, 16'($urandom_range(0, 2048)));
          write_reg(REG_KI, 16'($urandom_range(0, 64)));
          write_reg(REG_KD, 16'($urandom_range(0, 1024)));
          write_reg(REG_DEADBAND, 16'($urandom_range(0, 20)));
          write_reg(REG_DUTY_MAX, 16'($urandom_range(1, 1000)));
        end
      endcase
      n = 0;
      while (n < 210) begin
        if ($urandom_range(0, 9) == 0) begin
          push_noise();
          n++;
        end else begin
          push_segment(cnt);
          n += cnt;
        end
      end
      drain();
    end

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/rsph_pkg.sv
design/rsph_ctrl.sv
design/rsph_datapath.sv
design/ramp_setpoint_pid_heater_unit.sv
verif/ramp_setpoint_pid_heater_unit_tb.sv
